// ----- sv/ldpi_pkg.sv -----
package ldpi_pkg;

    localparam int LOAD_W     = 17;
    localparam int POWER_W    = 16;
    localparam int NUM_POINTS = 4;
    localparam int PROD_W     = LOAD_W + POWER_W;
    localparam int DIV_STEPS  = POWER_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LOAD_W;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    typedef logic [LOAD_W-1:0]  load_t;
    typedef logic [POWER_W-1:0] power_t;
    typedef logic [PROD_W-1:0]  prod_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT0_LOAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT1_LOAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT2_LOAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT3_LOAD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT0_POWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT1_POWER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POINT2_POWER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POINT3_POWER = 3'd7;

    // reset values of the breakpoints
    localparam load_t  RST_POINT0_LOAD  = 17'd0;
    localparam load_t  RST_POINT1_LOAD  = 17'd65536;
    localparam load_t  RST_POINT2_LOAD  = 17'd65536;
    localparam load_t  RST_POINT3_LOAD  = 17'd65536;
    localparam power_t RST_POINT0_POWER = 16'd100;
    localparam power_t RST_POINT1_POWER = 16'd200;
    localparam power_t RST_POINT2_POWER = 16'd200;
    localparam power_t RST_POINT3_POWER = 16'd200;

    // segment codes: below/at breakpoint 0, inside segment 1..3, above breakpoint 3
    localparam int SEG_W = 3;
    localparam logic [SEG_W-1:0] SEG_LOW  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_1    = 3'd1;
    localparam logic [SEG_W-1:0] SEG_2    = 3'd2;
    localparam logic [SEG_W-1:0] SEG_3    = 3'd3;
    localparam logic [SEG_W-1:0] SEG_HIGH = 3'd4;

endpackage

// ----- sv/load_to_power_interpolator.sv -----
// A request passes stage 1, stage 2, divider slots 0..16 and the output register.
// Throughput: one request per cycle; a request enters in every cycle that the
// output register is empty or is being taken, and the whole pipeline holds otherwise.
// Reset (aresetn low at a clock edge) empties every stage and loads the default
// breakpoints (0,100) (65536,200) (65536,200) (65536,200).
module load_to_power_interpolator
    import ldpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [16:0] load_sample, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [15:0] power_estimate
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Breakpoint registers
    // ------------------------------------------------------------------
    load_t  point_load_reg  [NUM_POINTS];
    power_t point_power_reg [NUM_POINTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_load_reg[0]  <= RST_POINT0_LOAD;
            point_load_reg[1]  <= RST_POINT1_LOAD;
            point_load_reg[2]  <= RST_POINT2_LOAD;
            point_load_reg[3]  <= RST_POINT3_LOAD;
            point_power_reg[0] <= RST_POINT0_POWER;
            point_power_reg[1] <= RST_POINT1_POWER;
            point_power_reg[2] <= RST_POINT2_POWER;
            point_power_reg[3] <= RST_POINT3_POWER;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POINT0_LOAD:  point_load_reg[0]  <= cfg_wdata;
                REG_POINT1_LOAD:  point_load_reg[1]  <= cfg_wdata;
                REG_POINT2_LOAD:  point_load_reg[2]  <= cfg_wdata;
                REG_POINT3_LOAD:  point_load_reg[3]  <= cfg_wdata;
                REG_POINT0_POWER: point_power_reg[0] <= cfg_wdata[POWER_W-1:0];
                REG_POINT1_POWER: point_power_reg[1] <= cfg_wdata[POWER_W-1:0];
                REG_POINT2_POWER: point_power_reg[2] <= cfg_wdata[POWER_W-1:0];
                REG_POINT3_POWER: point_power_reg[3] <= cfg_wdata[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together while the output
    // register is empty or being drained, and holds otherwise.
    // ------------------------------------------------------------------
    logic adv_en;
    logic out_vld_reg;

    assign adv_en   = !out_vld_reg || m_tready;
    assign s_tready = adv_en;

    // ------------------------------------------------------------------
    // Stage 1: compare the sample against all four breakpoints, pick the
    // first breakpoint at or above it.
    // ------------------------------------------------------------------
    logic             s1_vld_reg;
    load_t            s1_sample_reg;
    logic [SEG_W-1:0] s1_seg_reg;
    load_t            s1_sample_next;
    logic [SEG_W-1:0] s1_seg_next;

    always_comb begin
        s1_sample_next = s_tdata[LOAD_W-1:0];
        priority if (s1_sample_next <= point_load_reg[0]) s1_seg_next = SEG_LOW;
        else if (s1_sample_next <= point_load_reg[1])     s1_seg_next = SEG_1;
        else if (s1_sample_next <= point_load_reg[2])     s1_seg_next = SEG_2;
        else if (s1_sample_next <= point_load_reg[3])     s1_seg_next = SEG_3;
        else                                              s1_seg_next = SEG_HIGH;
    end

    // ------------------------------------------------------------------
    // Stage 2: form offset into the segment, segment width, power step
    // (sign and magnitude) and base power. Clamped cases get a zero step
    // and a unit width so the quotient comes out zero.
    // ------------------------------------------------------------------
    logic   s2_vld_reg;
    load_t  s2_dl_reg,   s2_dl_next;
    load_t  s2_den_reg,  s2_den_next;
    power_t s2_mag_reg,  s2_mag_next;
    logic   s2_neg_reg,  s2_neg_next;
    power_t s2_base_reg, s2_base_next;
    load_t  seg_lo, seg_hi;
    power_t seg_plo, seg_phi;

    always_comb begin
        seg_lo  = point_load_reg[0];
        seg_hi  = point_load_reg[1];
        seg_plo = point_power_reg[0];
        seg_phi = point_power_reg[1];
        unique case (s1_seg_reg)
            SEG_2: begin
                seg_lo  = point_load_reg[1];
                seg_hi  = point_load_reg[2];
                seg_plo = point_power_reg[1];
                seg_phi = point_power_reg[2];
            end
            SEG_3: begin
                seg_lo  = point_load_reg[2];
                seg_hi  = point_load_reg[3];
                seg_plo = point_power_reg[2];
                seg_phi = point_power_reg[3];
            end
            default: ;
        endcase

        s2_dl_next   = s1_sample_reg - seg_lo;
        s2_den_next  = seg_hi - seg_lo;
        s2_neg_next  = seg_phi < seg_plo;
        s2_mag_next  = s2_neg_next ? (seg_plo - seg_phi) : (seg_phi - seg_plo);
        s2_base_next = seg_plo;

        if (s1_seg_reg == SEG_LOW || s1_seg_reg == SEG_HIGH) begin
            s2_dl_next   = '0;
            s2_den_next  = load_t'(1);
            s2_neg_next  = 1'b0;
            s2_mag_next  = '0;
            s2_base_next = (s1_seg_reg == SEG_LOW) ? point_power_reg[0]
                                                   : point_power_reg[NUM_POINTS-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 (divider slot 0): exact product offset * |step|, 17x16 bits.
    // Divider slots 1..16: one restoring step each, quotient bit 15 first.
    // The offset never exceeds the width, so the quotient fits 16 bits.
    // ------------------------------------------------------------------
    logic [DIV_STEPS:0] dv_vld_reg;
    prod_t              dv_rem_reg  [DIV_STEPS+1];
    power_t             dv_quo_reg  [DIV_STEPS+1];
    load_t              dv_den_reg  [DIV_STEPS+1];
    logic               dv_neg_reg  [DIV_STEPS+1];
    power_t             dv_base_reg [DIV_STEPS+1];
    prod_t              prod_next;

    assign prod_next = prod_t'(s2_dl_reg) * prod_t'(s2_mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end else if (adv_en) begin
            s1_vld_reg    <= s_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            dv_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_en) begin
            s1_sample_reg  <= s1_sample_next;
            s1_seg_reg     <= s1_seg_next;
            s2_dl_reg      <= s2_dl_next;
            s2_den_reg     <= s2_den_next;
            s2_mag_reg     <= s2_mag_next;
            s2_neg_reg     <= s2_neg_next;
            s2_base_reg    <= s2_base_next;
            dv_rem_reg[0]  <= prod_next;
            dv_quo_reg[0]  <= '0;
            dv_den_reg[0]  <= s2_den_reg;
            dv_neg_reg[0]  <= s2_neg_reg;
            dv_base_reg[0] <= s2_base_reg;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        localparam int BIT = DIV_STEPS - j;
        prod_t               dsh;
        logic [PROD_W:0]     trial;
        prod_t               rem_next;
        power_t              quo_next;

        always_comb begin
            dsh      = prod_t'(dv_den_reg[j-1]) << BIT;
            trial    = {1'b0, dv_rem_reg[j-1]} - {1'b0, dsh};
            rem_next = dv_rem_reg[j-1];
            quo_next = dv_quo_reg[j-1];
            if (!trial[PROD_W]) begin
                rem_next      = trial[PROD_W-1:0];
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (adv_en) begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv_en) begin
                dv_rem_reg[j]  <= rem_next;
                dv_quo_reg[j]  <= quo_next;
                dv_den_reg[j]  <= dv_den_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_base_reg[j] <= dv_base_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply the sign of the step to the truncated quotient
    // and add the base power. The result stays between the two powers.
    // ------------------------------------------------------------------
    power_t out_power_reg;
    power_t out_power_next;

    assign out_power_next = dv_neg_reg[DIV_STEPS]
                          ? dv_base_reg[DIV_STEPS] - dv_quo_reg[DIV_STEPS]
                          : dv_base_reg[DIV_STEPS] + dv_quo_reg[DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv_en) begin
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_en) begin
            out_power_reg <= out_power_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_power_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // the product must leave a quotient that fits the power width
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[0] |-> (dv_rem_reg[0] < (prod_t'(dv_den_reg[0]) << DIV_STEPS)))
        else $error("product too large for a 16-bit quotient");

    // after the last step the remainder is below the segment width
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[DIV_STEPS] |-> (dv_rem_reg[DIV_STEPS] < prod_t'(dv_den_reg[DIV_STEPS])))
        else $error("divider remainder not reduced");

    // a live request never sees a zero segment width
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg |-> (s2_den_reg != '0 && s2_dl_reg <= s2_den_reg))
        else $error("segment width zero or offset beyond segment");

    // a stall holds every stage's valid bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv_en |=> ($stable(dv_vld_reg) && $stable(s1_vld_reg)
                     && $stable(s2_vld_reg) && $stable(out_vld_reg)))
        else $error("pipeline moved during stall");

endmodule
